// ===== hdl/mlam_pkg.sv =====
// Shared types and constants for the multi-loop audio mixer.
package mlam_pkg;

  localparam int LOOPS_DEF      = 16;
  localparam int MAX_FRAMES_DEF = 4096;

  localparam int IN_TDATA_W  = 72;
  localparam int OUT_TDATA_W = 24;
  localparam int KIND_W      = 2;
  localparam int IDX_W       = 7;
  localparam int ADDR_W      = 12;
  localparam int SAMPLE_W    = 16;
  localparam int LEN_W       = 13;
  localparam int GAIN_W      = 16;
  localparam int PROD_W      = SAMPLE_W + GAIN_W + 1;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  localparam int MIX_MAX = 8388607;
  localparam int MIX_MIN = -8388608;

  localparam logic [KIND_W-1:0] KIND_TICK  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_WRITE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_SET   = 2'd2;

  typedef enum logic [1:0] {
    OP_TICK,
    OP_WRITE,
    OP_SET
  } op_t;

  typedef struct packed {
    op_t                 op;
    logic [IDX_W-1:0]    loop_idx;
    logic [ADDR_W-1:0]   sample_addr;
    logic [SAMPLE_W-1:0] sample_value;
    logic                play_flag;
    logic                ready_flag;
    logic [LEN_W-1:0]    length;
    logic [GAIN_W-1:0]   gain;
  } cmd_t;

endpackage

// ===== hdl/mlam_front.sv =====
// Input front end: decodes and filters incoming transactions into a command queue.
module mlam_front #(
  parameter int LOOPS      = mlam_pkg::LOOPS_DEF,
  parameter int MAX_FRAMES = mlam_pkg::MAX_FRAMES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [mlam_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic [mlam_pkg::KIND_W-1:0]      in_tuser,
  output logic                             q_valid,
  input  logic                             q_ready,
  output mlam_pkg::cmd_t                   q_cmd
);
  import mlam_pkg::*;

  cmd_t             cmd;
  logic             keep;
  logic             push;
  logic             pop;
  logic [IDX_W-1:0] idx;
  logic [ADDR_W-1:0] addr;
  logic [LEN_W-1:0] fc;

  cmd_t             queue_r [QDEPTH];
  logic [QAW-1:0]   wr_r;
  logic [QAW-1:0]   rd_r;
  logic [QAW:0]     count_r;

  assign idx  = in_tdata[6:0];
  assign addr = in_tdata[18:7];
  assign fc   = in_tdata[49:37];

  always_comb begin
    cmd.op           = OP_TICK;
    cmd.loop_idx     = idx;
    cmd.sample_addr  = addr;
    cmd.sample_value = in_tdata[34:19];
    cmd.play_flag    = in_tdata[35];
    cmd.ready_flag   = in_tdata[36];
    cmd.length       = (32'(fc) > MAX_FRAMES) ? LEN_W'(MAX_FRAMES) : fc;
    cmd.gain         = in_tdata[65:50];
    keep             = 1'b0;
    case (in_tuser)
      KIND_TICK: begin
        cmd.op = OP_TICK;
        keep   = 1'b1;
      end
      KIND_WRITE: begin
        cmd.op = OP_WRITE;
        keep   = (32'(idx) < LOOPS) && (32'(addr) < MAX_FRAMES);
      end
      KIND_SET: begin
        cmd.op = OP_SET;
        keep   = 32'(idx) < LOOPS;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign in_tready = count_r != (QAW + 1)'(QDEPTH);
  assign push      = in_tvalid && in_tready && keep;
  assign q_valid   = count_r != '0;
  assign pop       = q_valid && q_ready;
  assign q_cmd     = queue_r[rd_r];

  always_ff @(posedge clk) begin
    if (push) begin
      queue_r[wr_r] <= cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r    <= '0;
      rd_r    <= '0;
      count_r <= '0;
    end else begin
      if (push) begin
        wr_r <= wr_r + 1'b1;
      end
      if (pop) begin
        rd_r <= rd_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

// ===== hdl/mlam_engine.sv =====
// Back end: sample memory, per-loop controls, mixing pipeline and output register.
module mlam_engine #(
  parameter int LOOPS      = mlam_pkg::LOOPS_DEF,
  parameter int MAX_FRAMES = mlam_pkg::MAX_FRAMES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             q_valid,
  output logic                             q_ready,
  input  mlam_pkg::cmd_t                   q_cmd,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [mlam_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                             out_tuser
);
  import mlam_pkg::*;

  localparam int LOOP_W    = (LOOPS > 1) ? $clog2(LOOPS) : 1;
  localparam int CNT_W     = $clog2(LOOPS + 3);
  localparam int MEM_DEPTH = LOOPS * MAX_FRAMES;
  localparam int MEM_AW    = $clog2(MEM_DEPTH);
  localparam int ACC_W     = PROD_W + $clog2(LOOPS) + 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_FIN
  } state_t;

  state_t                    state_r;
  logic [CNT_W-1:0]          cnt_r;
  logic                      act1_r;
  logic                      act2_r;
  logic [GAIN_W-1:0]         vol1_r;
  logic [SAMPLE_W-1:0]       rd_data_r;
  logic signed [PROD_W-1:0]  prod_r;
  logic signed [ACC_W-1:0]   acc_r;
  logic                      any_r;
  logic                      out_valid_r;
  logic [OUT_TDATA_W-1:0]    out_mix_r;
  logic                      out_any_r;

  logic [SAMPLE_W-1:0]       mem [MEM_DEPTH];
  logic [LEN_W-1:0]          pos_r  [LOOPS];
  logic [LEN_W-1:0]          len_r  [LOOPS];
  logic [GAIN_W-1:0]         vol_r  [LOOPS];
  logic                      play_r [LOOPS];
  logic                      rdy_r  [LOOPS];

  logic                      take;
  logic                      start;
  logic                      mem_we;
  logic                      set_we;
  logic [LOOP_W-1:0]         set_sel;
  logic                      issue;
  logic [LOOP_W-1:0]         sel;
  logic                      active;
  logic [LEN_W-1:0]          pos_eff;
  logic [MEM_AW-1:0]         rd_addr;
  logic [MEM_AW-1:0]         wr_addr;
  logic                      out_free;
  logic signed [PROD_W-1:0]  prod_nxt;
  logic signed [ACC_W:0]     rnd;
  logic signed [ACC_W:0]     shifted;
  logic [OUT_TDATA_W-1:0]    mix_nxt;

  assign q_ready  = state_r == S_IDLE;
  assign take     = q_valid && q_ready;
  assign start    = take && (q_cmd.op == OP_TICK);
  assign mem_we   = take && (q_cmd.op == OP_WRITE);
  assign set_we   = take && (q_cmd.op == OP_SET);
  assign set_sel  = q_cmd.loop_idx[LOOP_W-1:0];
  assign out_free = !out_valid_r || out_tready;

  assign issue   = (state_r == S_RUN) && (cnt_r < CNT_W'(LOOPS));
  assign sel     = issue ? cnt_r[LOOP_W-1:0] : '0;
  assign active  = issue && play_r[sel] && rdy_r[sel] && (len_r[sel] != '0);
  assign pos_eff = (pos_r[sel] >= len_r[sel]) ? '0 : pos_r[sel];
  assign rd_addr = MEM_AW'(32'(sel) * MAX_FRAMES + 32'(pos_eff));
  assign wr_addr = MEM_AW'(32'(set_sel) * MAX_FRAMES + 32'(q_cmd.sample_addr));

  assign prod_nxt = $signed(rd_data_r) * $signed({1'b0, vol1_r});

  always_comb begin
    rnd     = (ACC_W + 1)'(acc_r) + (ACC_W + 1)'(64);
    shifted = rnd >>> 7;
    if (shifted > $signed((ACC_W + 1)'(MIX_MAX))) begin
      mix_nxt = OUT_TDATA_W'(MIX_MAX);
    end else if (shifted < $signed((ACC_W + 1)'(MIX_MIN))) begin
      mix_nxt = OUT_TDATA_W'(MIX_MIN);
    end else begin
      mix_nxt = shifted[OUT_TDATA_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= q_cmd.sample_value;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LOOPS; i++) begin
        pos_r[i]  <= '0;
        len_r[i]  <= '0;
        vol_r[i]  <= '0;
        play_r[i] <= 1'b0;
        rdy_r[i]  <= 1'b0;
      end
    end else begin
      if (set_we) begin
        len_r[set_sel]  <= q_cmd.length;
        vol_r[set_sel]  <= q_cmd.gain;
        play_r[set_sel] <= q_cmd.play_flag;
        rdy_r[set_sel]  <= q_cmd.ready_flag;
      end
      if (active) begin
        pos_r[sel] <= pos_eff + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      act1_r      <= 1'b0;
      act2_r      <= 1'b0;
      any_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      act1_r <= active;
      vol1_r <= vol_r[sel];
      act2_r <= act1_r;
      prod_r <= prod_nxt;
      if (out_valid_r && out_tready && state_r != S_FIN) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (start) begin
            state_r <= S_RUN;
            cnt_r   <= '0;
            acc_r   <= '0;
            any_r   <= 1'b0;
          end
        end
        S_RUN: begin
          cnt_r <= cnt_r + 1'b1;
          if (act2_r) begin
            acc_r <= acc_r + ACC_W'(prod_r);
            any_r <= 1'b1;
          end
          if (cnt_r == CNT_W'(LOOPS + 1)) begin
            state_r <= S_FIN;
          end
        end
        S_FIN: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_mix_r   <= any_r ? mix_nxt : '0;
            out_any_r   <= any_r;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_mix_r;
  assign out_tuser  = out_any_r;

  a_silent_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_any_r |-> out_mix_r == '0)
    else $error("mix without contributing loops is not zero");

  a_drained_at_finish: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_FIN |-> !act1_r && !act2_r)
    else $error("mix pipeline not drained at finish");

  a_idle_takes_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE && q_valid |-> q_ready)
    else $error("idle engine stalls the command queue");

  a_no_issue_outside_run: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_RUN |=> !act1_r)
    else $error("loop issued outside a tick");

endmodule

// ===== hdl/multi_loop_audio_mixer.sv =====
// Top level of the multi-loop audio mixer: front end, command queue and mixing engine.
//
//   Channel   Direction  Handshake            Payload
//   in_       slave      in_tvalid/in_tready  tdata: loop/addr/sample/flags/length/gain
//                                             tuser: item kind
//   out_      master     out_tvalid/out_tready tdata: 24-bit mix, tuser: any-playing
//
// A tick runs one sample memory read per loop, then a two-stage multiply and
// accumulate tail, then rounds and saturates the sum into the output register.
// A four-entry command queue lets the input side run ahead of the engine.
// Reset is synchronous and active low; it clears all loop controls at once,
// and the sample memory holds no reset value.
// A stalled output holds the mix; the queue keeps accepting until it is full.
module multi_loop_audio_mixer #(
  parameter int LOOPS      = mlam_pkg::LOOPS_DEF,
  parameter int MAX_FRAMES = mlam_pkg::MAX_FRAMES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // loop_index[6:0], sample_addr[18:7], sample_value[34:19], play_flag[35],
  // ready_flag[36], frame_count[49:37], gain[65:50], zero fill[71:66]
  input  logic [mlam_pkg::IN_TDATA_W-1:0]  in_tdata,
  // kind[1:0]
  input  logic [mlam_pkg::KIND_W-1:0]      in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // mixed_sample[23:0]
  output logic [mlam_pkg::OUT_TDATA_W-1:0] out_tdata,
  // mix_active[0]
  output logic                             out_tuser
);
  import mlam_pkg::*;

  logic q_valid;
  logic q_ready;
  cmd_t q_cmd;

  mlam_front #(
    .LOOPS      (LOOPS),
    .MAX_FRAMES (MAX_FRAMES)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_cmd     (q_cmd)
  );

  mlam_engine #(
    .LOOPS      (LOOPS),
    .MAX_FRAMES (MAX_FRAMES)
  ) u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_ready    (q_ready),
    .q_cmd      (q_cmd),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule
